/* hdl/cbdq_pkg.sv */
// Opcode, status and controller state codes for the ring buffer deque.
package cbdq_pkg;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_READ_FRONT = 4'd4,
		OP_READ_BACK  = 4'd5,
		OP_READ_INDEX = 4'd6,
		OP_CLEAR      = 4'd7,
		OP_RESIZE     = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_FILL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

endpackage

/* hdl/cbdq_ram.sv */
// Single-port-write, single-port-read storage for the deque entries.
module cbdq_ram #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data is registered; it holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/circular_buffer_deque_unit.sv */
// Results: push, pop, clear, non-growing resize and refused requests enter the output register
// on acceptance (the pending register if it is full); reads pass through S_READ and a growing
// resize through S_FILL first. Throughput: one request per cycle while no result is parked; a read
// or growing resize holds new requests back until its result is made, as the entry memory takes
// one access per cycle; a parked result holds further requests back until it can leave.
// Reset (arst_n low, asynchronous) empties the deque; the entry memory itself is not cleared.
module circular_buffer_deque_unit
	import cbdq_pkg::*;
#(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int PW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1),
	localparam int IN_BITS   = DATA_WIDTH + PW + CW,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = DATA_WIDTH + CW + 1,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Request side.
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// From bit 0: data_word, position, target_count, zero padding.
	input  logic [IN_W-1:0]  s_axis_tdata,
	// opcode.
	input  logic [3:0]       s_axis_tuser,
	// Result side.
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// From bit 0: read_data, entry_count, is_empty, zero padding.
	output logic [OUT_W-1:0] m_axis_tdata,
	// status.
	output logic [1:0]       m_axis_tuser
);

	// Unpacked request fields.
	logic [DATA_WIDTH-1:0] in_word;
	logic [PW-1:0]         in_pos;
	logic [CW-1:0]         in_target;
	logic [3:0]            in_op;

	assign in_word   = s_axis_tdata[DATA_WIDTH-1:0];
	assign in_pos    = s_axis_tdata[DATA_WIDTH +: PW];
	assign in_target = s_axis_tdata[DATA_WIDTH + PW +: CW];
	assign in_op     = s_axis_tuser;

	// Pointer arithmetic modulo DEPTH, which need not be a power of two.
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [PW-1:0] k);
		logic [PW:0] sum;
		sum = {1'b0, p} + {1'b0, k};
		if (sum >= (PW+1)'(DEPTH)) begin
			sum = sum - (PW+1)'(DEPTH);
		end
		ptr_add = sum[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_sub(input logic [PW-1:0] p, input logic [PW-1:0] k);
		logic [PW:0] dif;
		if (p >= k) begin
			dif = {1'b0, p} - {1'b0, k};
		end else begin
			dif = {1'b0, p} + (PW+1)'(DEPTH) - {1'b0, k};
		end
		ptr_sub = dif[PW-1:0];
	endfunction

	// Architectural state.
	state_t                state_q, state_d;
	logic [PW-1:0]         head_q, head_d;
	logic [PW-1:0]         tail_q, tail_d;
	logic [CW-1:0]         count_q, count_d;

	// Resize fill in progress: the word to append and the count to stop at.
	logic [DATA_WIDTH-1:0] fill_word_q;
	logic [CW-1:0]         fill_target_q;

	// A result that could not enter the output register while it was still occupied.
	status_t               pend_status_q;
	logic [DATA_WIDTH-1:0] pend_rdata_q;
	logic [CW-1:0]         pend_count_q;

	// Output register.
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [DATA_WIDTH-1:0] out_rdata_q;
	logic [CW-1:0]         out_count_q;

	// Memory ports.
	logic                  mem_we;
	logic [PW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [PW-1:0]         mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	// Result produced in this cycle.
	logic                  res_valid;
	status_t               res_status;
	logic [DATA_WIDTH-1:0] res_rdata;

	logic                  s_accept;
	logic                  out_free;
	logic                  load_out;
	logic                  is_full;
	logic                  is_none;
	logic [CW-1:0]         cut_count;
	logic [PW-1:0]         cut_mod;

	// Requests are taken only when no earlier request is still being worked on; a finished
	// result waiting in the output register does not hold the next request back.
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign is_full = (count_q == CW'(DEPTH));
	assign is_none = (count_q == '0);

	// Entries dropped by a shrinking resize. Dropping all DEPTH entries leaves the tail in place.
	assign cut_count = count_q - in_target;
	assign cut_mod   = (cut_count == CW'(DEPTH)) ? '0 : cut_count[PW-1:0];

	cbdq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Only one memory access is started per cycle and a read is always finished before the
	// next request is taken, so a read never overlaps a write to the same entry.
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_rdata  = '0;
		mem_we     = 1'b0;
		mem_waddr  = tail_q;
		mem_wdata  = in_word;
		mem_re     = 1'b0;
		mem_raddr  = head_q;

		case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					res_valid = 1'b1;
					case (in_op)
						OP_PUSH_FRONT: begin
							if (is_full) begin
								res_status = ST_FULL;
							end else begin
								head_d    = ptr_dec(head_q);
								mem_we    = 1'b1;
								mem_waddr = ptr_dec(head_q);
								count_d   = count_q + 1'b1;
							end
						end
						OP_PUSH_BACK: begin
							if (is_full) begin
								res_status = ST_FULL;
							end else begin
								tail_d  = ptr_inc(tail_q);
								mem_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (is_none) begin
								res_status = ST_EMPTY;
							end else begin
								head_d  = ptr_inc(head_q);
								count_d = count_q - 1'b1;
							end
						end
						OP_POP_BACK: begin
							if (is_none) begin
								res_status = ST_EMPTY;
							end else begin
								tail_d  = ptr_dec(tail_q);
								count_d = count_q - 1'b1;
							end
						end
						OP_READ_FRONT: begin
							if (is_none) begin
								res_status = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								res_valid = 1'b0;
								state_d   = S_READ;
							end
						end
						OP_READ_BACK: begin
							if (is_none) begin
								res_status = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = ptr_dec(tail_q);
								res_valid = 1'b0;
								state_d   = S_READ;
							end
						end
						OP_READ_INDEX: begin
							if ({1'b0, in_pos} >= (PW+1)'(count_q)) begin
								res_status = ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = ptr_add(head_q, in_pos);
								res_valid = 1'b0;
								state_d   = S_READ;
							end
						end
						OP_CLEAR: begin
							head_d  = '0;
							tail_d  = '0;
							count_d = '0;
						end
						OP_RESIZE: begin
							if (in_target > CW'(DEPTH)) begin
								res_status = ST_FULL;
							end else if (in_target < count_q) begin
								tail_d  = ptr_sub(tail_q, cut_mod);
								count_d = in_target;
							end else if (in_target > count_q) begin
								res_valid = 1'b0;
								state_d   = S_FILL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				res_valid = 1'b1;
				res_rdata = mem_rdata;
				state_d   = S_IDLE;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = fill_word_q;
				tail_d    = ptr_inc(tail_q);
				count_d   = count_q + 1'b1;
				if (count_d == fill_target_q) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Park the result if the output register is still occupied.
		if (res_valid && !out_free) begin
			state_d = S_DONE;
		end
	end

	assign load_out = out_free && (res_valid || (state_q == S_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			fill_word_q   <= in_word;
			fill_target_q <= in_target;
		end
		if (res_valid && !out_free) begin
			pend_status_q <= res_status;
			pend_rdata_q  <= res_rdata;
			pend_count_q  <= count_d;
		end
		if (load_out) begin
			if (res_valid) begin
				out_status_q <= res_status;
				out_rdata_q  <= res_rdata;
				out_count_q  <= count_d;
			end else begin
				out_status_q <= pend_status_q;
				out_rdata_q  <= pend_rdata_q;
				out_count_q  <= pend_count_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({(out_count_q == '0), out_count_q, out_rdata_q});
	assign m_axis_tuser  = out_status_q;

endmodule
